// ----- rtl/swcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcd_pkg: shared definitions of the sliding window critical detector
// Window geometry, derived arithmetic widths, register indexes and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package swcd_pkg;

	// Window geometry
	localparam int WINDOW_LEN  = 5;
	localparam int SAMPLE_BITS = 16;

	// Configuration registers are 16 bits wide, except min_in_band
	localparam int CFG_W      = 16;
	localparam int MIB_W      = 3;
	localparam int CFG_ADDR_W = 3;
	localparam int TALLY_W    = 16;

	// Fill counter holds 0 .. WINDOW_LEN-1
	localparam int FILL_W = (WINDOW_LEN > 2) ? $clog2(WINDOW_LEN) : 1;
	// Count of readings in the window: 0 .. WINDOW_LEN
	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
	// Common width for comparing readings against 16 bit bounds
	localparam int VAL_W  = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
	// Sum of up to WINDOW_LEN values
	localparam int SUM_W  = VAL_W + CNT_W;
	// threshold * count, signed
	localparam int PROD_W = CFG_W + CNT_W + 1;
	// Width used for the mean comparison
	localparam int CMP_W  = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;
	// Width used for the in-band count comparison
	localparam int BCMP_W = (CNT_W > MIB_W) ? CNT_W : MIB_W;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	// Register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_VALID_LOW     = 3'd0,
		REG_VALID_HIGH    = 3'd1,
		REG_BAND_LOW      = 3'd2,
		REG_BAND_HIGH     = 3'd3,
		REG_MIN_IN_BAND   = 3'd4,
		REG_AVG_THRESHOLD = 3'd5
	} cfg_reg_t;

	// Reset values
	localparam logic signed [CFG_W-1:0] VALID_LOW_RST     = 16'sd0;
	localparam logic signed [CFG_W-1:0] VALID_HIGH_RST    = 16'sd150;
	localparam logic signed [CFG_W-1:0] BAND_LOW_RST      = 16'sd70;
	localparam logic signed [CFG_W-1:0] BAND_HIGH_RST     = 16'sd150;
	localparam logic [MIB_W-1:0]        MIN_IN_BAND_RST   = 3'd3;
	localparam logic signed [CFG_W-1:0] AVG_THRESHOLD_RST = 16'sd90;

endpackage

// ----- rtl/sliding_window_critical_detector_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_critical_detector_unit: critical window detector
// Keeps the last WINDOW_LEN readings and flags windows that have enough
// in-band readings and a high enough mean of the readings in valid range.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_ready) carries one signed reading and a
//   last flag per item. Result channel (result_valid/result_ready) returns
//   one item per input item: window_full, critical, critical_count and
//   end_of_run (copy of last). An item with last set closes the sequence:
//   its result carries the final count, then window and count restart.
//   Configuration is written through cfg_write/cfg_addr/cfg_data,
//   indexes above 5 are ignored; write only while the block is empty.
//   Path: the window snapshot is loaded into stage 1 when the item is
//   taken, and the result register loads from stage 1 when it advances.
//   Throughput: one item per cycle while result_ready stays high. State
//   carried across items is the window shift line and fill level at the
//   input and the saturating count in the result stage.
//   Stall: when result_ready is low the result register holds, the snapshot
//   stage fills, and item_ready drops only once both stages are occupied.
//   Reset: arst_n clears the window fill level, the count, both stage
//   valid flags, and loads the register defaults.
// ----------------------------------------------------------------------------
module sliding_window_critical_detector_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// input items
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic signed [swcd_pkg::SAMPLE_BITS-1:0] reading,
	input  logic                                last,
	// result items
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                window_full,
	output logic                                critical,
	output logic [swcd_pkg::TALLY_W-1:0]        critical_count,
	output logic                                end_of_run,
	// configuration writes
	input  logic                                cfg_write,
	input  logic [swcd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [swcd_pkg::CFG_W-1:0]          cfg_data
);
	import swcd_pkg::*;

	// configuration registers
	logic signed [CFG_W-1:0] valid_low_q;
	logic signed [CFG_W-1:0] valid_high_q;
	logic signed [CFG_W-1:0] band_low_q;
	logic signed [CFG_W-1:0] band_high_q;
	logic [MIB_W-1:0]        min_in_band_q;
	logic signed [CFG_W-1:0] avg_threshold_q;

	// window history and sequence state
	logic signed [SAMPLE_BITS-1:0] store_q [WINDOW_LEN-1];
	logic [FILL_W-1:0]             fill_q;
	logic [TALLY_W-1:0]            tally_q;
	logic                          full_now;

	// stage 1: window snapshot
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] win_s1 [WINDOW_LEN];
	logic                          full_s1;
	logic                          last_s1;

	// handshake
	logic accept_in;
	logic adv_s2;

	// evaluation
	logic signed [VAL_W-1:0]  win_ext [WINDOW_LEN];
	logic [CNT_W-1:0]         band_cnt;
	logic [CNT_W-1:0]         valid_cnt;
	logic signed [SUM_W-1:0]  valid_sum;
	logic signed [PROD_W-1:0] thr_p;
	logic signed [PROD_W-1:0] cnt_p;
	logic signed [PROD_W-1:0] thr_prod;
	logic                     band_ok;
	logic                     mean_ok;
	logic                     crit_s1;
	logic [TALLY_W-1:0]       tally_next;

	// Handshake: the result register frees when taken, stage 1 moves on then
	assign adv_s2     = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || adv_s2;
	assign accept_in  = item_valid && item_ready;
	assign full_now   = (fill_q == FILL_W'(WINDOW_LEN - 1));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_low_q     <= VALID_LOW_RST;
			valid_high_q    <= VALID_HIGH_RST;
			band_low_q      <= BAND_LOW_RST;
			band_high_q     <= BAND_HIGH_RST;
			min_in_band_q   <= MIN_IN_BAND_RST;
			avg_threshold_q <= AVG_THRESHOLD_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_VALID_LOW:     valid_low_q     <= cfg_data;
				REG_VALID_HIGH:    valid_high_q    <= cfg_data;
				REG_BAND_LOW:      band_low_q      <= cfg_data;
				REG_BAND_HIGH:     band_high_q     <= cfg_data;
				REG_MIN_IN_BAND:   min_in_band_q   <= cfg_data[MIB_W-1:0];
				REG_AVG_THRESHOLD: avg_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window history: plain shift line, not reset; only flags critical once it is full
	always_ff @(posedge clk) begin
		if (accept_in) begin
			for (int i = 0; i < WINDOW_LEN - 2; i++) begin
				store_q[i] <= store_q[i+1];
			end
			store_q[WINDOW_LEN-2] <= reading;
		end
	end

	// Fill level, restarts after the last item of a sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept_in) begin
			if (last) begin
				fill_q <= '0;
			end else if (!full_now) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Stage 1 payload: snapshot of the whole window
	always_ff @(posedge clk) begin
		if (accept_in) begin
			for (int i = 0; i < WINDOW_LEN - 1; i++) begin
				win_s1[i] <= store_q[i];
			end
			win_s1[WINDOW_LEN-1] <= reading;
			full_s1              <= full_now;
			last_s1              <= last;
		end
	end

	// Per-reading range checks, count and sum of valid readings
	always_comb begin
		band_cnt  = '0;
		valid_cnt = '0;
		valid_sum = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			win_ext[i] = VAL_W'(win_s1[i]);
			if (win_ext[i] >= VAL_W'(band_low_q) && win_ext[i] <= VAL_W'(band_high_q)) begin
				band_cnt = band_cnt + 1'b1;
			end
			if (win_ext[i] >= VAL_W'(valid_low_q) && win_ext[i] <= VAL_W'(valid_high_q)) begin
				valid_cnt = valid_cnt + 1'b1;
				valid_sum = valid_sum + SUM_W'(win_ext[i]);
			end
		end
	end

	// Exact mean test: sum >= threshold * count, count nonzero
	assign thr_p    = PROD_W'(avg_threshold_q);
	assign cnt_p    = PROD_W'(signed'({1'b0, valid_cnt}));
	assign thr_prod = thr_p * cnt_p;
	assign mean_ok  = (valid_cnt != '0) && (CMP_W'(valid_sum) >= CMP_W'(thr_prod));
	assign band_ok  = BCMP_W'(band_cnt) >= BCMP_W'(min_in_band_q);
	assign crit_s1  = full_s1 && band_ok && mean_ok;

	// Saturating critical count
	assign tally_next = (crit_s1 && tally_q != TALLY_MAX) ? tally_q + 1'b1 : tally_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
		end else if (adv_s2) begin
			tally_q <= last_s1 ? '0 : tally_next;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!result_valid || result_ready) begin
			result_valid <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			window_full    <= full_s1;
			critical       <= crit_s1;
			critical_count <= tally_next;
			end_of_run     <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_crit_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!critical || window_full))
		else $error("critical result on a window that is not full");

	a_last_restarts_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_in && last) |=> (fill_q == '0))
		else $error("fill level not cleared after last item");

	a_last_clears_tally: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && last_s1) |=> (tally_q == '0))
		else $error("critical count not cleared after end of sequence");

	a_tally_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && !last_s1 && crit_s1 && tally_q != TALLY_MAX)
		|=> (tally_q == $past(tally_q) + 1'b1))
		else $error("critical count did not advance by one");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(full_s1) && $stable(last_s1)))
		else $error("stage 1 item lost while stalled");

endmodule
